FILE: rtl/core/adp_pkg.sv
// Shared types and constants for the anisotropic diffusion pixel filter.
// Used by adp_cond, adp_accum and anisotropic_diffusion_pixel.
package adp_pkg;

   localparam int NUM_DIR    = 4;
   localparam int PIX_W      = 16;
   localparam int DIFF_W     = PIX_W + 1;
   localparam int COND_W     = 24;
   localparam int DEN_W      = 64;
   localparam int NUM_W      = 54;
   localparam int GAIN_SHIFT = 38;
   localparam int PROD_W     = COND_W + 1 + DIFF_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int CORR_W     = SUM_W - COND_W + 2;

   localparam logic [DEN_W-1:0] ONE_INV = DEN_W'(64'h4000_0000);

   localparam logic [1:0] REG_GUIDED_MODE = 2'd0;
   localparam logic [1:0] REG_INV_THR_SQ  = 2'd1;
   localparam logic [1:0] REG_GAIN        = 2'd2;

   typedef logic [NUM_DIR-1:0][DIFF_W-1:0] diff_vec_type;
   typedef logic [NUM_DIR-1:0][COND_W-1:0] cond_vec_type;

   typedef struct packed {
      logic             valid;
      logic             border;
      logic [PIX_W-1:0] centre;
   } side_type;

endpackage

FILE: rtl/core/adp_cond.sv
// Conductance pipeline: gain / (1 + g*g*inv_threshold_sq) for four directions.
// Squaring, product stage, then one restoring division bit per stage. Uses adp_pkg.
module adp_cond import adp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  diff_vec_type         diff_in,
   input  diff_vec_type         guide_in,
   input  side_type             side_in,
   input  logic [31:0]          inv_threshold_sq,
   input  logic [15:0]          gain,
   output cond_vec_type         cond_out,
   output diff_vec_type         diff_out,
   output side_type             side_out
);

   localparam int DSTG = COND_W;
   localparam int WIDE = DEN_W + COND_W;

   side_type     side_ff [0:DSTG+1];
   diff_vec_type diff_ff [0:DSTG+1];
   logic [NUM_DIR-1:0][31:0]       sq_ff;
   logic [NUM_DIR-1:0][DEN_W-1:0]  den_ff [0:DSTG];
   logic [NUM_DIR-1:0][NUM_W-1:0]  rem_ff [0:DSTG];
   logic [NUM_DIR-1:0][COND_W-1:0] quo_ff [0:DSTG];

   logic [NUM_DIR-1:0][31:0]       sq_in;
   logic [NUM_DIR-1:0][DEN_W-1:0]  den_in;

   always_comb begin
      for (int k = 0; k < NUM_DIR; k++) begin
         logic [DIFF_W-1:0] mag;
         mag = guide_in[k][DIFF_W-1] ? DIFF_W'(-guide_in[k]) : guide_in[k];
         sq_in[k]  = 32'(mag[PIX_W-1:0]) * 32'(mag[PIX_W-1:0]);
         den_in[k] = (DEN_W'(sq_ff[k]) * DEN_W'(inv_threshold_sq)) + ONE_INV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= DSTG + 1; j++) side_ff[j] <= '0;
      end else if (advance) begin
         side_ff[0] <= side_in;
         for (int j = 1; j <= DSTG + 1; j++) side_ff[j] <= side_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff      <= sq_in;
         diff_ff[0] <= diff_in;
         for (int j = 1; j <= DSTG + 1; j++) diff_ff[j] <= diff_ff[j-1];
         den_ff[0]  <= den_in;
         for (int k = 0; k < NUM_DIR; k++) begin
            rem_ff[0][k] <= {gain, GAIN_SHIFT'(0)};
            quo_ff[0][k] <= '0;
         end
      end
   end

   for (genvar j = 1; j <= DSTG; j++) begin : g_div
      localparam int SH = DSTG - j;
      logic [NUM_DIR-1:0][NUM_W-1:0]  rem_in;
      logic [NUM_DIR-1:0][COND_W-1:0] quo_in;

      always_comb begin
         for (int k = 0; k < NUM_DIR; k++) begin
            logic [WIDE-1:0] shifted;
            logic            fits;
            shifted = WIDE'(den_ff[j-1][k]) << SH;
            fits    = WIDE'(rem_ff[j-1][k]) >= shifted;
            rem_in[k] = fits ? (rem_ff[j-1][k] - shifted[NUM_W-1:0]) : rem_ff[j-1][k];
            quo_in[k] = quo_ff[j-1][k];
            quo_in[k][SH] = fits;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[j] <= den_ff[j-1];
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign cond_out = quo_ff[DSTG];
   assign diff_out = diff_ff[DSTG+1];
   assign side_out = side_ff[DSTG+1];

endmodule

FILE: rtl/core/adp_accum.sv
// Weighted sum of differences, round half to even, add to centre, saturate;
// border beats keep the centre. Four register stages. Uses adp_pkg.
module adp_accum import adp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  cond_vec_type     cond_in,
   input  diff_vec_type     diff_in,
   input  side_type         side_in,
   output logic             valid_out,
   output logic [PIX_W-1:0] filtered
);

   localparam logic [COND_W-1:0] HALF = COND_W'(1) << (COND_W - 1);
   localparam int RES_W = CORR_W + 1;

   side_type side_ff [0:2];
   logic signed [NUM_DIR-1:0][PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [CORR_W-1:0] corr_ff;
   logic                     valid_ff;
   logic [PIX_W-1:0]         filtered_ff;

   logic signed [NUM_DIR-1:0][PROD_W-1:0] prod_in;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [CORR_W-1:0] corr_in;
   logic [PIX_W-1:0]         filtered_in;

   always_comb begin
      logic [SUM_W-1:0]          mag;
      logic [SUM_W-COND_W-1:0]   quo;
      logic [COND_W-1:0]         frac;
      logic [SUM_W-COND_W:0]     rnd;
      logic signed [RES_W-1:0]   res;
      for (int k = 0; k < NUM_DIR; k++)
         prod_in[k] = $signed({1'b0, cond_in[k]}) * $signed(diff_in[k]);
      sum_in = '0;
      for (int k = 0; k < NUM_DIR; k++)
         sum_in = sum_in + SUM_W'($signed(prod_ff[k]));
      mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      quo  = mag[SUM_W-1:COND_W];
      frac = mag[COND_W-1:0];
      rnd  = {1'b0, quo} + ((frac > HALF || (frac == HALF && quo[0])) ? 1'b1 : 1'b0);
      corr_in = sum_ff[SUM_W-1] ? -$signed(CORR_W'(rnd)) : $signed(CORR_W'(rnd));
      res = RES_W'($signed(side_ff[2].centre)) + RES_W'(corr_ff);
      if (side_ff[2].border)
         filtered_in = side_ff[2].centre;
      else if (res > RES_W'(32767))
         filtered_in = 16'h7fff;
      else if (res < -RES_W'(32768))
         filtered_in = 16'h8000;
      else
         filtered_in = res[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0] <= '0;
         side_ff[1] <= '0;
         side_ff[2] <= '0;
         valid_ff   <= 1'b0;
      end else if (advance) begin
         side_ff[0] <= side_in;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         valid_ff   <= side_ff[2].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff     <= prod_in;
         sum_ff      <= sum_in;
         corr_ff     <= corr_in;
         filtered_ff <= filtered_in;
      end
   end

   assign valid_out = valid_ff;
   assign filtered  = filtered_ff;

endmodule

FILE: rtl/core/anisotropic_diffusion_pixel.sv
// Top level of the anisotropic diffusion pixel filter.
// Instantiates adp_cond and adp_accum; uses adp_pkg.
//
// One beat on req_ carries a pixel component's source cross and blurred cross;
// one beat on rsp_ returns the diffused value, in the same order.
// csr_ writes guided_mode (0), inv_threshold_sq (1) and gain (2); other
// indexes are ignored. Write only while no beat is in flight.
// From the accepting req_ edge to rsp_tvalid a beat passes through 31
// register stages: one input stage, two multiply stages, 24 division stages
// (one quotient bit per stage) and four stages for product, sum, rounding and
// saturation.
// Throughput is one beat per cycle. When rsp_tready is low with a result
// waiting, the whole pipeline holds and req_tready drops; nothing is lost.
// Reset clears all valid bits and loads register defaults: guided_mode 0,
// inv_threshold_sq 2^30, gain 16384.
// Border beats (req_tuser high) return the centre unchanged.
module anisotropic_diffusion_pixel import adp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // centre, above, below, left_px, right_px,
   // blur_centre, blur_above, blur_below, blur_left, blur_right
   input  logic [159:0] req_tdata,
   // at_border
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // filtered
   output logic [15:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic        guided_ff;
   logic [31:0] inv_ff;
   logic [15:0] gain_ff;

   logic         advance;
   diff_vec_type diff_ff, guide_ff, diff_in, guide_in;
   side_type     side_ff, side_in;
   cond_vec_type cond_c;
   diff_vec_type diff_c;
   side_type     side_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         guided_ff <= 1'b0;
         inv_ff    <= 32'h4000_0000;
         gain_ff   <= 16'h4000;
      end else if (csr_we) begin
         case (csr_index)
            REG_GUIDED_MODE: guided_ff <= csr_wdata[0];
            REG_INV_THR_SQ:  inv_ff    <= csr_wdata;
            REG_GAIN:        gain_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      logic [PIX_W-1:0] c, bc, n, bn;
      c  = req_tdata[PIX_W-1:0];
      bc = req_tdata[5*PIX_W +: PIX_W];
      for (int k = 0; k < NUM_DIR; k++) begin
         n  = req_tdata[(k+1)*PIX_W +: PIX_W];
         bn = req_tdata[(k+6)*PIX_W +: PIX_W];
         diff_in[k]  = {n[PIX_W-1], n} - {c[PIX_W-1], c};
         guide_in[k] = guided_ff ? diff_in[k] : ({bn[PIX_W-1], bn} - {bc[PIX_W-1], bc});
      end
      side_in.valid  = req_tvalid;
      side_in.border = req_tuser;
      side_in.centre = c;
   end

   always_ff @(posedge clock) begin
      if (reset)
         side_ff <= '0;
      else if (advance)
         side_ff <= side_in;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff  <= diff_in;
         guide_ff <= guide_in;
      end
   end

   adp_cond u_cond (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .diff_in          (diff_ff),
      .guide_in         (guide_ff),
      .side_in          (side_ff),
      .inv_threshold_sq (inv_ff),
      .gain             (gain_ff),
      .cond_out         (cond_c),
      .diff_out         (diff_c),
      .side_out         (side_c)
   );

   adp_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cond_in   (cond_c),
      .diff_in   (diff_c),
      .side_in   (side_c),
      .valid_out (rsp_tvalid),
      .filtered  (rsp_tdata)
   );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for anisotropic_diffusion_pixel.
// Drives pixel crosses over the req_ stream, predicts each diffused value and
// checks the rsp_ stream in order. Depends only on adp_pkg and the DUT.
module tb_top import adp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 40;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   logic        mode_guided;
   logic [31:0] inv_thr_sq;
   logic [15:0] gain_q16;

   logic [15:0] expected_filtered[$];
   int          mismatch_count = 0;
   int          beats_sent = 0;
   int          beats_checked = 0;
   int          settings_used = 0;
   bit          sender_burst = 0;
   bit          receiver_burst = 0;
   bit          hold_req = 0;

   anisotropic_diffusion_pixel DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [15:0] diffuse(input logic [15:0] px[10], input logic border);
      int                d;
      int                g;
      longint unsigned   mag;
      longint unsigned   den;
      longint unsigned   q;
      longint unsigned   r;
      longint            cond;
      longint            acc;
      longint            res;
      if (border) return px[0];
      acc = 0;
      for (int k = 0; k < 4; k++) begin
         d = int'($signed(px[k+1])) - int'($signed(px[0]));
         g = int'($signed(px[k+6])) - int'($signed(px[5]));
         if (mode_guided) g = d;
         mag = (g < 0) ? longint'(-g) : longint'(g);
         den = 64'h4000_0000 + mag * mag * longint'(inv_thr_sq);
         cond = longint'((longint'(gain_q16) << 38) / den);
         acc += cond * longint'(d);
      end
      mag = (acc < 0) ? longint'(-acc) : longint'(acc);
      q = mag >> 24;
      r = mag & 64'hFF_FFFF;
      if (r > 64'h80_0000 || (r == 64'h80_0000 && q[0])) q++;
      res = longint'($signed(px[0])) + ((acc < 0) ? -longint'(q) : longint'(q));
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return res[15:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] want,
                                  input logic [15:0] got);
      mismatch_count++;
      $display("MISMATCH %s: expected %0d got %0d at %0t", what, $signed(want),
               $signed(got), $realtime);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         REG_GUIDED_MODE: mode_guided = value[0];
         REG_INV_THR_SQ:  inv_thr_sq = value;
         REG_GAIN:        gain_q16 = value[15:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic guided, input logic [31:0] inv,
                                 input logic [15:0] gn);
      write_csr(REG_GUIDED_MODE, {31'd0, guided});
      write_csr(REG_INV_THR_SQ, inv);
      write_csr(REG_GAIN, {16'd0, gn});
      settings_used++;
   endtask

   task automatic drain;
      req_tvalid = 1'b0;
      while (expected_filtered.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_pixel(input logic [15:0] px[10], input logic border);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      for (int k = 0; k < 10; k++) req_tdata[16*k +: 16] = px[k];
      req_tuser = border;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_filtered.push_back(diffuse(px, border));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_random;
      logic [15:0] px[10];
      int          span;
      int          style;
      style = $urandom_range(0, 3);
      span = $urandom_range(0, 16);
      px[0] = 16'($urandom);
      px[5] = 16'($urandom);
      for (int k = 1; k < 5; k++) begin
         if (style == 0) begin
            px[k] = 16'($urandom);
            px[k+5] = 16'($urandom);
         end else begin
            px[k] = px[0] + 16'(($urandom & ((32'd1 << span) - 1)) - (32'd1 << span) / 2);
            px[k+5] = px[5] + 16'(($urandom & ((32'd1 << span) - 1)) - (32'd1 << span) / 2);
         end
      end
      send_pixel(px, $urandom_range(0, 15) == 0);
   endtask

   task automatic send_uniform(input logic [15:0] c, input logic [15:0] n,
                               input logic [15:0] bc, input logic [15:0] bn,
                               input logic border);
      logic [15:0] px[10];
      px[0] = c;
      px[5] = bc;
      for (int k = 1; k < 5; k++) begin
         px[k] = n;
         px[k+5] = bn;
      end
      send_pixel(px, border);
   endtask

   task automatic test_defaults_and_border;
      send_uniform(16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b1);
      send_uniform(16'h8000, 16'h7FFF, 16'h1234, 16'h0000, 1'b1);
      send_uniform(16'h0000, 16'h0004, 16'h0000, 16'h0000, 1'b0);
      send_uniform(16'h0100, 16'h00F0, 16'h0010, 16'h0011, 1'b0);
      drain();
   endtask

   task automatic test_extremes;
      apply_settings(1'b0, 32'd0, 16'hFFFF);
      send_uniform(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
      send_uniform(16'h7000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
      send_uniform(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
      send_uniform(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0);
      send_uniform(16'h9000, 16'h8000, 16'h0000, 16'h0000, 1'b0);
      send_uniform(16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b0);
      drain();
      apply_settings(1'b1, 32'hFFFF_FFFF, 16'hFFFF);
      send_uniform(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
      send_uniform(16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b0);
      send_uniform(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      drain();
      apply_settings(1'b1, 32'h0000_0001, 16'h0000);
      send_uniform(16'h1234, 16'h7FFF, 16'h0000, 16'h7FFF, 1'b0);
      send_uniform(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
      drain();
      write_csr(REG_UNUSED, 32'hFFFF_FFFF);
      apply_settings(1'b0, 32'h4000_0000, 16'h4000);
      send_uniform(16'h0000, 16'h0002, 16'h0000, 16'h0000, 1'b0);
      send_uniform(16'h0000, 16'hFFFE, 16'h0000, 16'h0000, 1'b0);
      drain();
      // ties: gain 2^-3 with four equal odd steps gives exact halves
      apply_settings(1'b0, 32'h4000_0000, 16'h2000);
      send_uniform(16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b0);
      send_uniform(16'h0000, 16'h0003, 16'h0000, 16'h0000, 1'b0);
      send_uniform(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      send_uniform(16'h0000, 16'hFFFD, 16'h0000, 16'h0000, 1'b0);
      drain();
   endtask

   task automatic test_random_settings;
      for (int phase = 0; phase < 4; phase++) begin
         apply_settings(1'($urandom_range(0, 1)), $urandom >> $urandom_range(0, 31),
                        16'($urandom_range(0, 65535)));
         sender_burst = (phase == 2);
         receiver_burst = (phase == 2);
         repeat (250) send_random();
         sender_burst = 0;
         receiver_burst = 0;
         drain();
      end
   endtask

   task automatic test_backpressure;
      apply_settings(1'b1, 32'h0010_0000, 16'hC000);
      hold_req = 1;
      sender_burst = 1;
      repeat (100) send_random();
      sender_burst = 0;
      drain();
   endtask

   initial begin
      mode_guided = 1'b0;
      inv_thr_sq = 32'h4000_0000;
      gain_q16 = 16'h4000;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_defaults_and_border();
      test_extremes();
      test_random_settings();
      test_backpressure();
      $display("Covered %0d beats checked of %0d sent over %0d register settings,",
               beats_checked, beats_sent, settings_used);
      $display("including border, saturation, ties, both modes and a long output stall.");
      if (mismatch_count == 0 && expected_filtered.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int n;
      wait (!reset);
      forever begin
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
            hold_req = 0;
         end
         n = receiver_burst ? 0 : $urandom_range(0, 19);
         if (n != 0) begin
            rsp_tready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_filtered.size() == 0) begin
            report_mismatch("unexpected beat", 16'h0000, rsp_tdata);
         end else begin
            if (rsp_tdata !== expected_filtered[0])
               report_mismatch("filtered", expected_filtered[0], rsp_tdata);
            void'(expected_filtered.pop_front());
            beats_checked++;
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/adp_pkg.sv
rtl/core/adp_cond.sv
rtl/core/adp_accum.sv
rtl/core/anisotropic_diffusion_pixel.sv
tb/sv/tb_top.sv
